// ----- src/cursor_array_list_assert.svh -----
// assertion macros for the list rtl, included by the sequencer cal_ctrl
// each macro has a real body and an empty body selected by ASSERT_OFF
`ifndef CURSOR_ARRAY_LIST_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ASSERT_SVH

`ifndef ASSERT_OFF
// check that is switched off while reset is held
`define CAL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("cal check failed");
// check that also holds while reset is held
`define CAL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("cal check failed");
`else
`define CAL_ASSERT(lbl, clk, rst_n, prop)
`define CAL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- src/cal_pkg.sv -----
// shared types and constants of the cursor array list
// no dependencies
`default_nettype none

package cal_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 4;
    localparam int POS_W        = 8;
    localparam int STATUS_W     = 2;
    localparam int LEN_OUT_W    = 8;
    localparam int CUR_OUT_W    = 9;

    typedef enum logic [OP_W-1:0] {
        OP_INS_AFTER = 4'd0,
        OP_INS_AT    = 4'd1,
        OP_UPDATE    = 4'd2,
        OP_REMOVE_AT = 4'd3,
        OP_REMOVE    = 4'd4,
        OP_START     = 4'd5,
        OP_END       = 4'd6,
        OP_NEXT      = 4'd7,
        OP_BACK      = 4'd8,
        OP_QUERY     = 4'd9
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK     = 2'd0,
        STS_FULL   = 2'd1,
        STS_BADIDX = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_OPEN,
        CM_CLOSE,
        CM_WRITE
    } t_cell_mode;

    typedef struct packed {
        t_cell_mode mode;
        logic       load_rd;
        logic       shift_rd;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- src/cal_cell.sv -----
// one slot of the list: holds one entry and one stage of the read chain
// depends on cal_pkg
`default_nettype none

module cal_cell #(
    parameter int CAPACITY = cal_pkg::CAPACITY_DEF,
    parameter int INDEX    = 0
) (
    input  wire logic                          i_clk,
    input  wire cal_pkg::t_cell_ctl            i_ctl,
    input  wire logic [$clog2(CAPACITY)-1:0]   i_k,
    input  wire logic [cal_pkg::DATA_W-1:0]    i_value,
    input  wire logic [cal_pkg::DATA_W-1:0]    i_left,
    input  wire logic [cal_pkg::DATA_W-1:0]    i_right,
    input  wire logic [cal_pkg::DATA_W-1:0]    i_rd_right,
    output logic      [cal_pkg::DATA_W-1:0]    o_entry,
    output logic      [cal_pkg::DATA_W-1:0]    o_rd
);
    import cal_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        case (i_ctl.mode)
            CM_OPEN: begin
                if (MY_IDX > i_k) begin
                    r_entry <= i_left;
                end else if (MY_IDX == i_k) begin
                    r_entry <= i_value;
                end
            end
            CM_CLOSE: begin
                if (MY_IDX >= i_k) begin
                    r_entry <= i_right;
                end
            end
            CM_WRITE: begin
                if (MY_IDX == i_k) begin
                    r_entry <= i_value;
                end
            end
            default: begin
                r_entry <= r_entry;
            end
        endcase

        // read chain walks entries down toward slot zero
        if (i_ctl.load_rd) begin
            r_rd <= r_entry;
        end else if (i_ctl.shift_rd) begin
            r_rd <= i_rd_right;
        end
    end

    assign o_entry = r_entry;
    assign o_rd    = r_rd;

endmodule

`default_nettype wire

// ----- src/cal_ctrl.sv -----
// sequencer of the list: decodes a request, steers the slots, fetches the
// entry under the cursor over the read chain and holds the result; uses cal_pkg
`default_nettype none

module cal_ctrl #(
    parameter int CAPACITY = cal_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [cal_pkg::OP_W-1:0]        i_operation,
    input  wire logic [cal_pkg::POS_W-1:0]       i_position,
    input  wire logic [cal_pkg::DATA_W-1:0]     i_rd0,
    output cal_pkg::t_cell_ctl                   o_ctl,
    output logic      [$clog2(CAPACITY)-1:0]     o_k,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [cal_pkg::STATUS_W-1:0]    o_status,
    output logic      [cal_pkg::LEN_OUT_W-1:0]   o_length_now,
    output logic signed [cal_pkg::DATA_W-1:0]    o_current_value,
    output logic                                 o_current_valid,
    output logic signed [cal_pkg::CUR_OUT_W-1:0] o_cursor_position
);
    import cal_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CUR_W = LEN_W + 1;
    localparam int CMP_W = ((LEN_W > POS_W) ? LEN_W : POS_W) + 2;

    localparam logic signed [CMP_W-1:0] S_ZERO = CMP_W'(0);
    localparam logic signed [CMP_W-1:0] S_ONE  = CMP_W'(1);
    localparam logic signed [CMP_W-1:0] S_CAP  = CMP_W'(CAPACITY);

    t_state                    r_state, n_state;
    logic [LEN_W-1:0]          r_len, n_len;
    logic signed [CUR_W-1:0]   r_cur, n_cur;
    t_status                   r_status, n_status;
    logic                      r_cur_valid, n_cur_valid;
    logic [IDX_W-1:0]          r_cnt;

    logic                      r_o_valid;
    t_status                   r_o_status;
    logic [LEN_OUT_W-1:0]      r_o_len;
    logic [DATA_W-1:0]         r_o_value;
    logic                      r_o_cur_valid;
    logic [CUR_OUT_W-1:0]      r_o_cur;

    logic                      accept;
    logic                      out_free;
    t_cell_mode                d_mode;
    logic signed [CMP_W-1:0]   k_s;
    logic signed [CMP_W-1:0]   len_s, cur_s, pos_s, nlen_s, ncur_s;
    logic                      full;

    assign accept   = i_valid && !o_stall;
    assign out_free = !r_o_valid || !i_stall;

    // request decode: new length, cursor, status and the slot command
    always_comb begin
        len_s    = CMP_W'(r_len);
        cur_s    = CMP_W'(r_cur);
        pos_s    = CMP_W'(i_position);
        full     = (len_s >= S_CAP);
        n_len    = r_len;
        n_cur    = r_cur;
        n_status = STS_OK;
        d_mode   = CM_HOLD;
        k_s      = S_ZERO;
        case (t_op'(i_operation))
            OP_INS_AFTER: begin
                if (full) begin
                    n_status = STS_FULL;
                end else begin
                    k_s = cur_s + S_ONE;
                    if (k_s > len_s) begin
                        k_s = len_s;
                    end
                    if (k_s < S_ZERO) begin
                        k_s = S_ZERO;
                    end
                    d_mode = CM_OPEN;
                    n_len  = r_len + LEN_W'(1);
                    n_cur  = CUR_W'(k_s);
                end
            end
            OP_INS_AT: begin
                if (full) begin
                    n_status = STS_FULL;
                end else if (len_s == S_ZERO && pos_s == S_ONE) begin
                    // lenient insert at one on an empty list
                    k_s    = S_ZERO;
                    d_mode = CM_OPEN;
                    n_len  = r_len + LEN_W'(1);
                    n_cur  = CUR_W'(k_s);
                end else if (pos_s <= len_s) begin
                    k_s    = pos_s;
                    d_mode = CM_OPEN;
                    n_len  = r_len + LEN_W'(1);
                    n_cur  = CUR_W'(k_s);
                end else begin
                    n_status = STS_BADIDX;
                end
            end
            OP_UPDATE: begin
                if (pos_s >= S_ONE && pos_s <= len_s) begin
                    k_s    = pos_s - S_ONE;
                    d_mode = CM_WRITE;
                    n_cur  = CUR_W'(k_s);
                end else begin
                    n_status = STS_BADIDX;
                end
            end
            OP_REMOVE_AT: begin
                if (pos_s >= S_ONE && pos_s <= len_s) begin
                    k_s    = pos_s - S_ONE;
                    d_mode = CM_CLOSE;
                    n_len  = r_len - LEN_W'(1);
                    n_cur  = CUR_W'(k_s);
                end else begin
                    n_status = STS_BADIDX;
                end
            end
            OP_REMOVE: begin
                if (cur_s >= S_ZERO && cur_s < len_s) begin
                    k_s    = cur_s;
                    d_mode = CM_CLOSE;
                    n_len  = r_len - LEN_W'(1);
                end else begin
                    n_status = STS_BADIDX;
                end
            end
            OP_START: begin
                n_cur = CUR_W'(0);
            end
            OP_END: begin
                n_cur = CUR_W'(len_s - S_ONE);
            end
            OP_NEXT: begin
                if (cur_s < len_s - S_ONE) begin
                    n_cur = r_cur + CUR_W'(1);
                end
            end
            OP_BACK: begin
                if (cur_s > S_ZERO) begin
                    n_cur = r_cur - CUR_W'(1);
                end
            end
            default: begin
                n_cur = r_cur;
            end
        endcase
        nlen_s      = CMP_W'(n_len);
        ncur_s      = CMP_W'(n_cur);
        n_cur_valid = (ncur_s >= S_ZERO) && (ncur_s < nlen_s);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_cur_valid && r_cur[IDX_W-1:0] != '0) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (r_cnt == IDX_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall        = (r_state != S_IDLE) || !i_rst_n;
        o_ctl.mode     = (r_state == S_IDLE && accept) ? d_mode : CM_HOLD;
        o_ctl.load_rd  = (r_state == S_LOAD);
        o_ctl.shift_rd = (r_state == S_SHIFT);
        o_k            = k_s[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_cur       <= '1;
            r_status    <= STS_OK;
            r_cur_valid <= 1'b0;
            r_cnt       <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && accept) begin
                r_len       <= n_len;
                r_cur       <= n_cur;
                r_status    <= n_status;
                r_cur_valid <= n_cur_valid;
            end
            if (r_state == S_LOAD) begin
                r_cnt <= r_cur[IDX_W-1:0];
            end else if (r_state == S_SHIFT) begin
                r_cnt <= r_cnt - IDX_W'(1);
            end
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_status    <= r_status;
            r_o_len       <= LEN_OUT_W'(r_len);
            r_o_value     <= r_cur_valid ? i_rd0 : '1;
            r_o_cur_valid <= r_cur_valid;
            r_o_cur       <= CUR_OUT_W'(r_cur);
        end
    end

    assign o_valid           = r_o_valid;
    assign o_status          = r_o_status;
    assign o_length_now      = r_o_len;
    assign o_current_value   = r_o_value;
    assign o_current_valid   = r_o_cur_valid;
    assign o_cursor_position = r_o_cur;

`include "cursor_array_list_assert.svh"

    `CAL_ASSERT(a_accept_then_busy, i_clk, i_rst_n, (i_valid && !o_stall) |=> o_stall)
    `CAL_ASSERT(a_len_only_on_request, i_clk, i_rst_n, ($past(i_rst_n) && r_len != $past(r_len)) |-> $past(i_valid && !o_stall))
    `CAL_ASSERT(a_shift_count_live, i_clk, i_rst_n, (r_state == S_SHIFT) |-> (r_cnt != '0))
    `CAL_ASSERT(a_valid_cursor_in_list, i_clk, i_rst_n, r_cur_valid |-> (r_cur >= 0 && r_len != '0))
    `CAL_ASSERT_ALWAYS(a_reset_blocks_input, i_clk, !i_rst_n |-> o_stall)

endmodule

`default_nettype wire

// ----- src/cursor_array_list.sv -----
// top level of the cursor array list: a row of slots and their sequencer
// depends on cal_pkg, cal_cell and cal_ctrl
//
//  channel   direction  handshake          payload
//  request   in         i_valid / o_stall  i_operation, i_value, i_position
//  result    out        o_valid / i_stall  o_status, o_length_now, o_current_value,
//                                          o_current_valid, o_cursor_position
//
// a request first updates the slots, then copies them into the read chain, then walks
// the entry under the cursor down to slot zero (skipped when no entry is under it or
// it already sits in slot zero) and last writes the result register
// inserts and removals shift all later slots together, in the slot update
// reset is synchronous, active low; o_stall is high while reset is held
// a held result stalls the sequencer only at its last cycle
`default_nettype none

module cursor_array_list #(
    parameter int CAPACITY = cal_pkg::CAPACITY_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [cal_pkg::OP_W-1:0]        i_operation,
    input  wire logic signed [cal_pkg::DATA_W-1:0] i_value,
    input  wire logic [cal_pkg::POS_W-1:0]       i_position,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [cal_pkg::STATUS_W-1:0]    o_status,
    output logic      [cal_pkg::LEN_OUT_W-1:0]   o_length_now,
    output logic signed [cal_pkg::DATA_W-1:0]    o_current_value,
    output logic                                 o_current_valid,
    output logic signed [cal_pkg::CUR_OUT_W-1:0] o_cursor_position
);
    import cal_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    t_cell_ctl         w_ctl;
    logic [IDX_W-1:0]  w_k;
    logic [DATA_W-1:0] w_entry [CAPACITY];
    logic [DATA_W-1:0] w_rd    [CAPACITY];

    cal_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_position        (i_position),
        .i_rd0             (w_rd[0]),
        .o_ctl             (w_ctl),
        .o_k               (w_k),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_length_now      (o_length_now),
        .o_current_value   (o_current_value),
        .o_current_valid   (o_current_valid),
        .o_cursor_position (o_cursor_position)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_slot
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        logic [DATA_W-1:0] w_rd_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right    = '0;
            assign w_rd_right = '0;
        end else begin : g_mid_r
            assign w_right    = w_entry[g+1];
            assign w_rd_right = w_rd[g+1];
        end

        cal_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_slot (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_k        (w_k),
            .i_value    (i_value),
            .i_left     (w_left),
            .i_right    (w_right),
            .i_rd_right (w_rd_right),
            .o_entry    (w_entry[g]),
            .o_rd       (w_rd[g])
        );
    end

endmodule

`default_nettype wire
